@@ rtl/core/smif_pkg.sv @@
// ----------------------------------------------------------------------------
// smif_pkg: shared types and constants
// Key set sizing, command codes, word structs and the slot hash.
// ----------------------------------------------------------------------------
package smif_pkg;

  localparam int CAPACITY   = 64;
  localparam int KEY_W      = 32;
  localparam int TBL_DEPTH  = 1 << $clog2(CAPACITY);
  localparam int IDX_W      = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_PROBE  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic signed [31:0] key;
  } in_word_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] key_out;
    logic               set_full;
  } out_word_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [KEY_W-1:0] wr_data;
    logic [IDX_W-1:0] rd_addr;
  } ram_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_t;

  // xor-fold of the key onto the table index
  function automatic logic [IDX_W-1:0] hash_key(input logic [KEY_W-1:0] k);
    logic [IDX_W-1:0] h;
    h = '0;
    for (int i = 0; i < KEY_W; i++) begin
      h[i % IDX_W] = h[i % IDX_W] ^ k[i];
    end
    return h;
  endfunction

endpackage

@@ rtl/core/smif_ram.sv @@
// ----------------------------------------------------------------------------
// smif_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module smif_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/core/smif_engine.sv @@
// ----------------------------------------------------------------------------
// smif_engine: hash table lookup / insert sequencer
// Linear probing over the key RAM; slot valid bits and entry count in flops.
// ----------------------------------------------------------------------------
module smif_engine
  import smif_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  in_word_t         word_in,
  input  logic [KEY_W-1:0] rd_data,
  output logic             busy,
  output logic             fin,
  output out_word_t        res,
  output ram_req_t         req
);

  state_t           state, state_next;
  in_word_t         cur, cur_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] steps, steps_next;
  logic [CNT_W-1:0] count, count_next;
  logic             valid [TBL_DEPTH];
  logic             clr_all;
  logic             set_slot;

  logic slot_ok, match, last_slot, room;

  assign slot_ok   = valid[idx];
  assign match     = slot_ok && (rd_data == KEY_W'(cur.key));
  assign last_slot = (steps == IDX_W'(TBL_DEPTH - 1));
  assign room      = (count < CNT_W'(CAPACITY));
  assign busy      = (state != ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && (word_in.command inside {CMD_INSERT, CMD_PROBE})) begin
          state_next = ST_READ;
        end
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: begin
        if (match || !slot_ok || last_slot) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_READ;
        end
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath next values
  always_comb begin
    fin         = 1'b0;
    res.hit     = 1'b0;
    res.key_out = cur.key;
    res.set_full = 1'b0;
    req.wr_en   = 1'b0;
    req.wr_addr = idx;
    req.wr_data = KEY_W'(cur.key);
    req.rd_addr = idx;
    cur_next    = cur;
    idx_next    = idx;
    steps_next  = steps;
    count_next  = count;
    clr_all     = 1'b0;
    set_slot    = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          cur_next    = word_in;
          idx_next    = hash_key(KEY_W'(word_in.key));
          steps_next  = '0;
          res.key_out = word_in.key;
          if (!(word_in.command inside {CMD_INSERT, CMD_PROBE})) begin
            fin = 1'b1;
          end
          if (word_in.command == CMD_CLEAR) begin
            clr_all    = 1'b1;
            count_next = '0;
          end
        end
      end
      ST_READ: ;
      ST_CHECK: begin
        if (match) begin
          fin     = 1'b1;
          res.hit = (cur.command == CMD_PROBE);
        end else if (!slot_ok) begin
          fin = 1'b1;
          if (cur.command == CMD_INSERT) begin
            if (room) begin
              req.wr_en  = 1'b1;
              set_slot   = 1'b1;
              count_next = count + CNT_W'(1);
              res.hit    = 1'b1;
            end else begin
              res.set_full = 1'b1;
            end
          end
        end else if (last_slot) begin
          // wrapped the whole table: it is full, key absent
          fin          = 1'b1;
          res.set_full = (cur.command == CMD_INSERT);
        end else begin
          idx_next   = idx + IDX_W'(1);
          steps_next = steps + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    cur   <= cur_next;
    idx   <= idx_next;
    steps <= steps_next;
  end

  always_ff @(posedge clk) begin
    if (rst || clr_all) begin
      for (int i = 0; i < TBL_DEPTH; i++) begin
        valid[i] <= 1'b0;
      end
    end else if (set_slot) begin
      valid[idx] <= 1'b1;
    end
  end

endmodule

@@ rtl/core/set_membership_intersection_filter.sv @@
// ----------------------------------------------------------------------------
// set_membership_intersection_filter: hash set of signed keys
// Clear / insert / probe commands, one result word per command word.
// ----------------------------------------------------------------------------
//
//   channel   ports                      handshake
//   -------   ------------------------   -----------------------------------
//   command   request (in_word_t)        taken when start && !busy
//   result    result (out_word_t)        valid for one cycle while done high
//
// Cycles: clear and the unused code take 1 cycle (result word the cycle
//   after). Insert and probe visit each table slot in a RAM read state, then
//   a compare state, and end with the result register. The key RAM's
//   registered read is why every slot visit needs its own read state.
// Reset: synchronous; empties the set (slot valid flops, entry count).
// Stalls: none on the result side; the engine is free for a new word
//   in the same cycle its previous result sits on the result ports.
//
module set_membership_intersection_filter
  import smif_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_word_t  request,
  output logic      done,
  output out_word_t result
);

  logic             take;
  logic             fin;
  out_word_t        res;
  ram_req_t         req;
  logic [KEY_W-1:0] rd_data;

  assign take = start && !busy;

  // key store: every slot is read; a key only counts while its valid flop is set
  smif_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TBL_DEPTH)
  ) u_keys (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_addr (req.rd_addr),
    .rd_data (rd_data)
  );

  // probe sequencer: hash, linear probe, insert at first empty slot
  smif_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .word_in (request),
    .rd_data (rd_data),
    .busy    (busy),
    .fin     (fin),
    .res     (res),
    .req     (req)
  );

  // result register: one-cycle strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
    if (fin) begin
      result <= res;
    end
  end

endmodule

@@ tb/smif_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smif_checker: result scoreboard for the key set filter
// Tracks the key set from accepted command words, predicts each result word
// and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module smif_checker
  import smif_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  request,
  input  logic      done,
  input  out_word_t result,
  output int        mismatches,
  output int        outstanding,
  output int        words_checked,
  output int        drops_seen
);

  // shadow copy of the set, keys packed in slots 0 .. member_count-1
  logic [KEY_W-1:0] member_key [CAPACITY];
  int               member_count;
  out_word_t        expected_results [$];
  int               mismatch_count;

  assign mismatches = mismatch_count;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
  endtask

  function automatic bit holds_key(input logic [KEY_W-1:0] k);
    for (int i = 0; i < member_count; i++) begin
      if (member_key[i] == k) return 1'b1;
    end
    return 1'b0;
  endfunction

  // next result word of the set for one command word; updates the shadow set
  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    r.hit      = 1'b0;
    r.key_out  = w.key;
    r.set_full = 1'b0;
    case (w.command)
      CMD_CLEAR: begin
        member_count = 0;
      end
      CMD_INSERT: begin
        if (!holds_key(w.key)) begin
          if (member_count < CAPACITY) begin
            member_key[member_count] = w.key;
            member_count++;
            r.hit = 1'b1;
          end else begin
            r.set_full = 1'b1;
          end
        end
      end
      CMD_PROBE: begin
        r.hit = holds_key(w.key);
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  initial begin
    mismatch_count = 0;
    member_count   = 0;
    outstanding    = 0;
    words_checked  = 0;
    drops_seen     = 0;
  end

  always @(posedge clk) begin
    out_word_t want;
    out_word_t pred;
    if (rst) begin
      member_count = 0;
      expected_results.delete();
    end else begin
      // the result of an older word is checked before a new word is queued
      if (done) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result word with none pending, key %h",
                                    result.key_out));
        end else begin
          want = expected_results.pop_front();
          words_checked <= words_checked + 1;
          if (result.hit !== want.hit)
            report_mismatch($sformatf("hit %b, want %b, key %h",
                                      result.hit, want.hit, want.key_out));
          if (result.key_out !== want.key_out)
            report_mismatch($sformatf("key_out %h, want %h",
                                      result.key_out, want.key_out));
          if (result.set_full !== want.set_full)
            report_mismatch($sformatf("set_full %b, want %b, key %h",
                                      result.set_full, want.set_full, want.key_out));
        end
      end
      if (start && !busy) begin
        pred = apply_command(request);
        if (pred.set_full) drops_seen <= drops_seen + 1;
        expected_results = {expected_results, pred};
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: top level testbench for set_membership_intersection_filter
// Drives command words (directed corner cases, then random insert / probe
// rounds under several sender idling profiles); smif_checker predicts and
// scores every result word.
// ----------------------------------------------------------------------------
module tb;
  import smif_pkg::*;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_word_t  request;
  logic      done;
  out_word_t result;

  int mismatches;
  int outstanding;
  int words_checked;
  int drops_seen;

  // stimulus bookkeeping
  int idle_pct;
  int words_sent;
  int inserts_sent;
  int probes_sent;
  int clears_sent;
  int nops_sent;

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  set_membership_intersection_filter dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  smif_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .mismatches    (mismatches),
    .outstanding   (outstanding),
    .words_checked (words_checked),
    .drops_seen    (drops_seen)
  );

  // Present one command word and hold it until the block takes it.
  // Idle cycles go in front of the word at idle_pct percent per cycle;
  // start is only lowered when a gap is actually inserted, so back to back
  // words keep start high with a single assignment per edge.
  task automatic send_word(input cmd_t c, input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    request <= '{command: c, key: k};
    @(posedge clk);
    // busy read here is the value the edge saw, so this is the accept test
    while (busy) @(posedge clk);
    words_sent++;
    case (c)
      CMD_CLEAR:  clears_sent++;
      CMD_INSERT: inserts_sent++;
      CMD_PROBE:  probes_sent++;
      default:    nops_sent++;
    endcase
  endtask

  // Stop sending and wait for every pending result word. The first edge is
  // always waited out, so the count already includes the last accepted word.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // A key that lands on the same home slot as anchor: flipping bit i and bit
  // i+6m cancels in the xor fold of the slot hash, forcing linear probing.
  function automatic logic [KEY_W-1:0] same_slot_key(input logic [KEY_W-1:0] anchor);
    logic [KEY_W-1:0] flip;
    flip = KEY_W'($urandom_range(1, 63));
    return anchor ^ flip ^ (flip << (6 * $urandom_range(1, 4)));
  endfunction

  function automatic logic [KEY_W-1:0] extreme_key();
    case ($urandom_range(3))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  // One well-formed round: optional clear, a batch of inserts (fresh keys,
  // slot collisions, repeats, extremes), then probes about half drawn from what
  // was inserted. Now and then a stray word (any code) breaks the sequence.
  // About one round in ten inserts 60 to 72 keys, near or past capacity, to hit the full-set drop.
  task automatic set_round();
    logic [KEY_W-1:0] anchor;
    logic [KEY_W-1:0] pool [$];
    logic [KEY_W-1:0] k;
    int               n_ins;
    int               n_probe;
    int               pick;
    anchor = $urandom();
    if ($urandom_range(3) != 0) send_word(CMD_CLEAR, $urandom());
    n_ins = ($urandom_range(9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 16);
    repeat (n_ins) begin
      pick = $urandom_range(9);
      if (pick < 4)
        k = $urandom();
      else if (pick < 7)
        k = same_slot_key(anchor);
      else if (pick < 9 && pool.size() > 0)
        k = pool[$urandom_range(pool.size() - 1)];
      else
        k = extreme_key();
      pool = {pool, k};
      send_word(CMD_INSERT, k);
      if ($urandom_range(19) == 0) send_word(cmd_t'($urandom_range(3)), $urandom());
    end
    n_probe = $urandom_range(1, 20);
    repeat (n_probe) begin
      pick = $urandom_range(9);
      if (pick < 5)
        k = pool[$urandom_range(pool.size() - 1)];
      else if (pick < 8)
        k = same_slot_key(anchor);
      else
        k = $urandom();
      send_word(CMD_PROBE, k);
    end
  endtask

  // watchdog: far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("FAIL");
    $finish;
  end

  initial begin
    int phase_start;
    int phase_idle [3];
    phase_idle   = '{0, 84, 23};
    idle_pct     = 0;
    words_sent   = 0;
    inserts_sent = 0;
    probes_sent  = 0;
    clears_sent  = 0;
    nops_sent    = 0;
    rst     <= 1'b1;
    start   <= 1'b0;
    request <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corner cases
    send_word(CMD_PROBE,  32'h0000_0000);   // probe of an empty set
    send_word(CMD_INSERT, 32'h8000_0000);   // most negative key
    send_word(CMD_INSERT, 32'h7fff_ffff);   // most positive key
    send_word(CMD_INSERT, 32'h0000_0000);
    send_word(CMD_INSERT, 32'hffff_ffff);
    send_word(CMD_INSERT, 32'h8000_0000);   // duplicate: not added again
    send_word(CMD_INSERT, 32'h0000_0041);   // same home slot as key 0
    send_word(CMD_PROBE,  32'h8000_0000);
    send_word(CMD_PROBE,  32'h7fff_ffff);
    send_word(CMD_PROBE,  32'h0000_0000);
    send_word(CMD_PROBE,  32'hffff_ffff);
    send_word(CMD_PROBE,  32'h0000_0041);
    send_word(CMD_PROBE,  32'h0000_1041);   // absent
    send_word(CMD_PROBE,  32'h0000_0001);   // absent
    send_word(CMD_NOP,    32'h5a5a_5a5a);   // unused code, key echoed
    send_word(CMD_NOP,    32'h8000_0000);   // unused code on a present key
    send_word(CMD_CLEAR,  32'hdead_beef);   // clear echoes its key
    send_word(CMD_PROBE,  32'h7fff_ffff);   // gone after clear
    send_word(CMD_INSERT, 32'h7fff_ffff);   // re-added after clear
    send_word(CMD_PROBE,  32'h7fff_ffff);
    wait_idle();

    // random rounds: no gaps, heavy gaps, light gaps, then bursty
    for (int p = 0; p < 4; p++) begin
      phase_start = words_sent;
      while (words_sent - phase_start < 230) begin
        if (p < 3)
          idle_pct = phase_idle[p];
        else
          idle_pct = ($urandom_range(1) == 0) ? 0 : 60;
        set_round();
      end
      // hold off until the set has answered every word of the phase
      wait_idle();
    end

    idle_pct = 0;
    wait_idle();
    // longest search: a read and a compare for each slot of the table, plus the result register
    repeat (2 * TBL_DEPTH + 20) @(posedge clk);

    $display("covered %0d words: %0d inserts, %0d probes, %0d clears, %0d unused code",
             words_sent, inserts_sent, probes_sent, clears_sent, nops_sent);
    $display("%0d result words compared, %0d inserts dropped on a full set",
             words_checked, drops_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
